// File: rtl/core/length_prefix_deframer_core_macros.svh
// Assertion macros for the length prefix deframer.
// Each macro expects signals named clk and rst in the module that uses it.
`ifndef LENGTH_PREFIX_DEFRAMER_CORE_MACROS_SVH
`define LENGTH_PREFIX_DEFRAMER_CORE_MACROS_SVH

`ifndef SYNTH
`define LPD_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("length_prefix_deframer_core: same-cycle check failed");
`define LPD_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("length_prefix_deframer_core: next-cycle check failed");
`else
`define LPD_ASSERT_IMP(label, ante, cons)
`define LPD_ASSERT_NXT(label, ante, cons)
`endif

`endif

// File: rtl/core/lpd_pkg.sv
package lpd_pkg;

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  // Register index is taken from this address bit (registers lie at 4*i).
  localparam int REG_IDX_BIT = 2;

  localparam logic REG_HEADER_LEN     = 1'b0;
  localparam logic REG_MAX_PACKET_LEN = 1'b1;

  localparam logic [4:0]  HEADER_LEN_MIN       = 5'd4;
  localparam logic [4:0]  HEADER_LEN_RESET     = 5'd4;
  localparam logic [31:0] MAX_PACKET_LEN_RESET = 32'd65536;

  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_SHORT = 2'd1;
  localparam logic [1:0] ERR_LONG  = 2'd2;

  typedef struct packed {
    logic [4:0]  header_len;
    logic [31:0] max_packet_len;
  } lpd_cfg_t;

endpackage

// File: rtl/core/lpd_if.sv
interface lpd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface lpd_result_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic [31:0] byte_offset;
  logic        is_header;
  logic        last;
  logic [1:0]  error_code;

  modport source (output valid, output out_byte, output byte_offset, output is_header,
                  output last, output error_code, input ready);
  modport sink (input valid, input out_byte, input byte_offset, input is_header,
                input last, input error_code, output ready);
endinterface

// File: rtl/core/length_prefix_deframer_core.sv
// Channel  | Role   | Payload
// ---------+--------+-------------------------------------------------------
// stream   | sink   | data_byte
// result   | source | out_byte, byte_offset, is_header, last, error_code
// apb      | slave  | header_len at 0x0, max_packet_len at 0x4
//
// Every accepted byte yields exactly one result, in the cycle after acceptance.
// Throughput is one byte per cycle while result.ready is high; the offset counter
// update and its length compares sit between the input handshake and the result register.
// rst is synchronous: it clears the packet state, drops result.valid and
// restores header_len to 4 and max_packet_len to 65536.
// stream.ready is low only while a result is held and result.ready is low.
`include "length_prefix_deframer_core_macros.svh"

module length_prefix_deframer_core (
  input  logic                            clk,
  input  logic                            rst,
  lpd_byte_if.sink                        stream,
  lpd_result_if.source                    result,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [lpd_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [lpd_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [lpd_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready
);

  lpd_pkg::lpd_cfg_t cfg;

  lpd_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  logic [31:0] received_count;
  logic [31:0] received_count_next;
  logic [31:0] packet_length;
  logic [31:0] packet_length_next;
  logic        header_done;
  logic        header_done_next;

  logic        out_valid;
  logic [7:0]  out_byte;
  logic [31:0] out_offset;
  logic        out_is_header;
  logic        out_last;
  logic [1:0]  out_error;

  logic        accept;
  logic [4:0]  hl;
  logic [31:0] hl_wide;
  logic [31:0] count_inc;
  logic [31:0] length_merged;
  logic        is_hdr_c;
  logic        last_c;
  logic [1:0]  err_c;

  assign stream.ready = !out_valid || result.ready;
  assign accept       = stream.valid && stream.ready;

  assign hl        = (cfg.header_len < lpd_pkg::HEADER_LEN_MIN) ? lpd_pkg::HEADER_LEN_MIN
                                                                 : cfg.header_len;
  assign hl_wide   = {27'd0, hl};
  assign count_inc = received_count + 32'd1;

  // The length word is built little-endian from the first four header bytes.
  always_comb begin
    length_merged = packet_length;
    if (received_count[31:2] == 30'd0) begin
      unique case (received_count[1:0])
        2'd0: length_merged[7:0]   = packet_length[7:0]   | stream.data_byte;
        2'd1: length_merged[15:8]  = packet_length[15:8]  | stream.data_byte;
        2'd2: length_merged[23:16] = packet_length[23:16] | stream.data_byte;
        2'd3: length_merged[31:24] = packet_length[31:24] | stream.data_byte;
      endcase
    end
  end

  always_comb begin
    received_count_next = count_inc;
    packet_length_next  = packet_length;
    header_done_next    = header_done;
    is_hdr_c            = 1'b0;
    last_c              = 1'b0;
    err_c               = lpd_pkg::ERR_NONE;
    if (!header_done) begin
      is_hdr_c           = 1'b1;
      packet_length_next = length_merged;
      if (count_inc >= hl_wide) begin
        priority if (length_merged < hl_wide) begin
          err_c = lpd_pkg::ERR_SHORT;
        end else if (length_merged > cfg.max_packet_len) begin
          err_c = lpd_pkg::ERR_LONG;
        end else if (count_inc >= length_merged) begin
          last_c = 1'b1;
        end else begin
          header_done_next = 1'b1;
        end
      end
    end else if (count_inc >= packet_length) begin
      last_c = 1'b1;
    end
    // An error or the end of a packet sends the block back to header search.
    if (last_c || (err_c != lpd_pkg::ERR_NONE)) begin
      received_count_next = 32'd0;
      packet_length_next  = 32'd0;
      header_done_next    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      received_count <= 32'd0;
      packet_length  <= 32'd0;
      header_done    <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (accept) begin
        received_count <= received_count_next;
        packet_length  <= packet_length_next;
        header_done    <= header_done_next;
        out_valid      <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_byte      <= stream.data_byte;
      out_offset    <= received_count;
      out_is_header <= is_hdr_c;
      out_last      <= last_c;
      out_error     <= err_c;
    end
  end

  assign result.valid       = out_valid;
  assign result.out_byte    = out_byte;
  assign result.byte_offset = out_offset;
  assign result.is_header   = out_is_header;
  assign result.last        = out_last;
  assign result.error_code  = out_error;

  `LPD_ASSERT_IMP(a_last_no_error, result.valid && result.last,
                  result.error_code == lpd_pkg::ERR_NONE)
  `LPD_ASSERT_IMP(a_error_in_header, result.valid && (result.error_code != lpd_pkg::ERR_NONE),
                  result.is_header)
  `LPD_ASSERT_NXT(a_restart_after_end, accept && (last_c || (err_c != lpd_pkg::ERR_NONE)),
                  (received_count == 32'd0) && !header_done && (packet_length == 32'd0))
  `LPD_ASSERT_IMP(a_header_count_small, !header_done, received_count[31:5] == 27'd0)

endmodule

// File: rtl/core/lpd_regs.sv
module lpd_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [lpd_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [lpd_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [lpd_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready,
  output lpd_pkg::lpd_cfg_t               cfg
);

  logic [4:0]  header_len;
  logic [31:0] max_packet_len;
  logic        wr_en;
  logic        reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[lpd_pkg::REG_IDX_BIT];

  always_ff @(posedge clk) begin
    if (rst) begin
      header_len     <= lpd_pkg::HEADER_LEN_RESET;
      max_packet_len <= lpd_pkg::MAX_PACKET_LEN_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        lpd_pkg::REG_HEADER_LEN: begin
          header_len <= pwdata[4:0];
        end
        lpd_pkg::REG_MAX_PACKET_LEN: begin
          max_packet_len <= pwdata[31:0];
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      lpd_pkg::REG_HEADER_LEN: begin
        prdata = {27'd0, header_len};
      end
      lpd_pkg::REG_MAX_PACKET_LEN: begin
        prdata = max_packet_len;
      end
    endcase
  end

  assign cfg.header_len     = header_len;
  assign cfg.max_packet_len = max_packet_len;

endmodule
